// File: hdl/triangular_lattice_gas_propagation_core_defines.svh
// Assertion macros shared by the lattice gas propagation RTL.
`ifndef TRIANGULAR_LATTICE_GAS_PROPAGATION_CORE_DEFINES_SVH
`define TRIANGULAR_LATTICE_GAS_PROPAGATION_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk, idle during reset.
`define TLG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, idle during reset.
`define TLG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/tlg_pkg.sv
// Shared types and constants of the lattice gas propagation core.
`default_nettype none
package tlg_pkg;

  localparam int ROW_W     = 16;
  localparam int COL_W     = 10;
  localparam int NCOL_W    = 11;
  localparam int CELL_W    = 3;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 1'b1;

  // input item kinds
  localparam logic MODE_CELL  = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  // particle bit positions within a cell
  localparam int BIT_SIDE = 0;
  localparam int BIT_UP   = 1;  // filled from the cell above
  localparam int BIT_DOWN = 2;  // filled from the cell below

  localparam logic [ROW_W-1:0]  NUM_ROWS_RST = 16'd1024;
  localparam logic [NCOL_W-1:0] NUM_COLS_RST = 11'd1024;

  // one result request, launched with the line store reads
  typedef struct packed {
    logic             emit;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
    logic             above_ok;
    logic             side_ok;
    logic             below_up;
  } tlg_req_t;

endpackage
`default_nettype wire

// File: hdl/tlg_line_mem.sv
// Two-row line store: one write port and two registered read ports.
`default_nettype none
module tlg_line_mem #(
  parameter int MAX_COLS = 1024
) (
  input  wire                              clk,
  input  wire                              wr_en,
  input  wire                              wr_half,
  input  wire  [$clog2(MAX_COLS)-1:0]      wr_col,
  input  wire  [tlg_pkg::CELL_W-1:0]       wr_data,
  input  wire                              rd_en,
  input  wire                              ra_half,
  input  wire  [$clog2(MAX_COLS)-1:0]      ra_col,
  input  wire                              rb_half,
  input  wire  [$clog2(MAX_COLS)-1:0]      rb_col,
  output logic [tlg_pkg::CELL_W-1:0]       ra_data,
  output logic [tlg_pkg::CELL_W-1:0]       rb_data
);

  localparam int AW = $clog2(MAX_COLS);
  localparam int IW = AW + 1;

  logic [tlg_pkg::CELL_W-1:0] mem [0:2*MAX_COLS-1];

  function automatic logic [IW-1:0] row_idx(input logic half, input logic [AW-1:0] col);
    logic [IW-1:0] base;
    base = half ? IW'(MAX_COLS) : '0;
    return base + {1'b0, col};
  endfunction

  // read-first: a read of the entry being written returns the old cell
  always_ff @(posedge clk) begin
    if (rd_en) begin
      ra_data <= mem[row_idx(ra_half, ra_col)];
      rb_data <= mem[row_idx(rb_half, rb_col)];
    end
    if (wr_en) begin
      mem[row_idx(wr_half, wr_col)] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// File: hdl/tlg_seq.sv
// Raster sequencer: config registers, position counters, store addressing.
`default_nettype none
module tlg_seq #(
  parameter int MAX_COLS = 1024
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               accept,
  input  wire                               mode,
  input  wire  [tlg_pkg::CELL_W-1:0]        cell_value,
  input  wire                               cfg_we,
  input  wire  [tlg_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire  [tlg_pkg::CFG_W-1:0]         cfg_data,
  output tlg_pkg::tlg_req_t                 req,
  output logic                              wr_en,
  output logic                              wr_half,
  output logic [$clog2(MAX_COLS)-1:0]       wr_col,
  output logic                              above_half,
  output logic [$clog2(MAX_COLS)-1:0]       above_col,
  output logic                              side_half,
  output logic [$clog2(MAX_COLS)-1:0]       side_col
);

  localparam int AW     = $clog2(MAX_COLS);
  localparam int ROW_W  = tlg_pkg::ROW_W;
  localparam int NCOL_W = tlg_pkg::NCOL_W;

  logic [ROW_W-1:0]  num_rows_r;
  logic [NCOL_W-1:0] num_cols_r;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt;
  logic [NCOL_W-1:0] in_col_r, in_col_nxt;
  logic [NCOL_W-1:0] drain_col_r, drain_col_nxt;
  logic              draining_r, draining_nxt;

  logic [ROW_W-1:0]  rows_eff;
  logic [NCOL_W-1:0] cols_eff;
  logic              col_wrap, row_wrap, drain_last;
  logic [ROW_W-1:0]  cur_row;
  logic [NCOL_W-1:0] cur_col, side_c;
  logic [NCOL_W:0]   col_p1;
  logic              side_even;

  always_comb begin
    rows_eff = (num_rows_r == '0) ? ROW_W'(1) : num_rows_r;
    priority if (num_cols_r == '0) begin
      cols_eff = NCOL_W'(1);
    end else if (32'(num_cols_r) > MAX_COLS) begin
      cols_eff = NCOL_W'(MAX_COLS);
    end else begin
      cols_eff = num_cols_r;
    end
  end

  assign col_wrap   = ({1'b0, in_col_r} + 1'b1) >= {1'b0, cols_eff};
  assign row_wrap   = ({1'b0, in_row_r} + 1'b1) >= {1'b0, rows_eff};
  assign drain_last = ({1'b0, drain_col_r} + 1'b1) >= {1'b0, cols_eff};

  // streaming emits the row above the arriving one; draining emits the held row
  assign cur_row   = draining_r ? in_row_r : in_row_r - ROW_W'(1);
  assign cur_col   = draining_r ? drain_col_r : in_col_r;
  assign side_even = (cur_row[0] == cur_col[0]);
  assign col_p1    = {1'b0, cur_col} + 1'b1;
  assign side_c    = side_even ? col_p1[NCOL_W-1:0] : cur_col - NCOL_W'(1);

  always_comb begin
    req.emit     = accept && (draining_r ? (mode == tlg_pkg::MODE_DRAIN)
                                         : (mode == tlg_pkg::MODE_CELL && in_row_r != '0));
    req.row      = cur_row;
    req.col      = cur_col[tlg_pkg::COL_W-1:0];
    req.last     = draining_r && drain_last;
    req.above_ok = (cur_row != '0);
    req.side_ok  = side_even ? (col_p1 < {1'b0, cols_eff}) : (cur_col != '0);
    req.below_up = !draining_r && (in_row_r < rows_eff) && cell_value[tlg_pkg::BIT_UP];
  end

  assign wr_en      = accept && (mode == tlg_pkg::MODE_CELL) && !draining_r;
  assign wr_half    = in_row_r[0];
  assign wr_col     = AW'(in_col_r);
  assign above_half = ~cur_row[0];
  assign above_col  = AW'(cur_col);
  assign side_half  = cur_row[0];
  assign side_col   = AW'(side_c);

  always_comb begin
    in_row_nxt    = in_row_r;
    in_col_nxt    = in_col_r;
    drain_col_nxt = drain_col_r;
    draining_nxt  = draining_r;
    if (accept) begin
      if (!draining_r && mode == tlg_pkg::MODE_CELL) begin
        if (col_wrap) begin
          in_col_nxt = '0;
          if (row_wrap) begin
            draining_nxt  = 1'b1;
            drain_col_nxt = '0;
          end else begin
            in_row_nxt = in_row_r + ROW_W'(1);
          end
        end else begin
          in_col_nxt = in_col_r + NCOL_W'(1);
        end
      end else if (draining_r && mode == tlg_pkg::MODE_DRAIN) begin
        if (drain_last) begin
          in_row_nxt    = '0;
          in_col_nxt    = '0;
          drain_col_nxt = '0;
          draining_nxt  = 1'b0;
        end else begin
          drain_col_nxt = drain_col_r + NCOL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r  <= tlg_pkg::NUM_ROWS_RST;
      num_cols_r  <= tlg_pkg::NUM_COLS_RST;
      in_row_r    <= '0;
      in_col_r    <= '0;
      drain_col_r <= '0;
      draining_r  <= 1'b0;
    end else begin
      in_row_r    <= in_row_nxt;
      in_col_r    <= in_col_nxt;
      drain_col_r <= drain_col_nxt;
      draining_r  <= draining_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          tlg_pkg::CFG_NUM_ROWS: num_rows_r <= cfg_data;
          tlg_pkg::CFG_NUM_COLS: num_cols_r <= cfg_data[NCOL_W-1:0];
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/tlg_out.sv
// Result stage: merges store read data into a cell, then the output register.
`default_nettype none
module tlg_out (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                accept,
  input  tlg_pkg::tlg_req_t                  req,
  input  wire  [tlg_pkg::CELL_W-1:0]         above_data,
  input  wire  [tlg_pkg::CELL_W-1:0]         side_data,
  input  wire                                out_ready,
  output logic                               take,
  output logic                               out_valid,
  output logic [tlg_pkg::CELL_W-1:0]         out_cell,
  output logic [tlg_pkg::ROW_W-1:0]          out_row,
  output logic [tlg_pkg::COL_W-1:0]          out_col,
  output logic                               out_last
);

  tlg_pkg::tlg_req_t          s1_r;
  logic                       s1_v_r;
  logic                       out_valid_r;
  logic [tlg_pkg::CELL_W-1:0] cell_r;
  logic [tlg_pkg::ROW_W-1:0]  row_r;
  logic [tlg_pkg::COL_W-1:0]  col_r;
  logic                       last_r;
  logic                       adv;
  logic [tlg_pkg::CELL_W-1:0] merged;

  assign adv  = !out_valid_r || out_ready;
  assign take = !s1_v_r || adv;

  always_comb begin
    merged                    = '0;
    merged[tlg_pkg::BIT_SIDE] = s1_r.side_ok && side_data[tlg_pkg::BIT_SIDE];
    merged[tlg_pkg::BIT_UP]   = s1_r.above_ok && above_data[tlg_pkg::BIT_DOWN];
    merged[tlg_pkg::BIT_DOWN] = s1_r.below_up;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r <= req.emit;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= req;
    end
    if (adv && s1_v_r) begin
      cell_r <= merged;
      row_r  <= s1_r.row;
      col_r  <= s1_r.col;
      last_r <= s1_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_cell  = cell_r;
  assign out_row   = row_r;
  assign out_col   = col_r;
  assign out_last  = last_r;

endmodule
`default_nettype wire

// File: hdl/triangular_lattice_gas_propagation_core.sv
// Top level of the triangular lattice gas propagation core.
// Takes one cell or drain beat per cycle, back to back, with stalls only from output
// back-pressure; each result is registered with the store reads, then in the output
// register. The rate is set by the two-row line store, which does two reads (cell
// above, side neighbor) per accepted beat and one write (arriving cell) per accepted
// cell beat. Cells arrive in raster order; cell (r,c) is emitted when cell (r+1,c)
// arrives, and after the whole frame, one drain beat (tuser = 1) per cell emits the
// last row, tlast marking the frame's last cell. Cell beats during draining are dropped.
// No clearing pass after reset. Write num_rows and num_cols only between frames.
`default_nettype none
module triangular_lattice_gas_propagation_core #(
  parameter int MAX_COLS = 1024
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [7:0]                       in_tdata,   // [2:0] cell_value
  input  wire                              in_tuser,   // [0] mode
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [31:0]                      out_tdata,  // [2:0] new_cell, [18:3] row_out,
                                                       // [28:19] col_out
  output logic                             out_tlast,
  input  wire                              cfg_we,
  input  wire  [tlg_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire  [tlg_pkg::CFG_W-1:0]        cfg_data
);

  localparam int AW = $clog2(MAX_COLS);

  logic                       accept;
  tlg_pkg::tlg_req_t          req;
  logic                       wr_en, wr_half, above_half, side_half;
  logic [AW-1:0]              wr_col, above_col, side_col;
  logic [tlg_pkg::CELL_W-1:0] above_data, side_data;
  logic [tlg_pkg::CELL_W-1:0] out_cell;
  logic [tlg_pkg::ROW_W-1:0]  out_row;
  logic [tlg_pkg::COL_W-1:0]  out_col;

  assign accept = in_tvalid && in_tready;

  tlg_seq #(.MAX_COLS(MAX_COLS)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .mode       (in_tuser),
    .cell_value (in_tdata[tlg_pkg::CELL_W-1:0]),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .req        (req),
    .wr_en      (wr_en),
    .wr_half    (wr_half),
    .wr_col     (wr_col),
    .above_half (above_half),
    .above_col  (above_col),
    .side_half  (side_half),
    .side_col   (side_col)
  );

  tlg_line_mem #(.MAX_COLS(MAX_COLS)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_half (wr_half),
    .wr_col  (wr_col),
    .wr_data (in_tdata[tlg_pkg::CELL_W-1:0]),
    .rd_en   (accept),
    .ra_half (above_half),
    .ra_col  (above_col),
    .rb_half (side_half),
    .rb_col  (side_col),
    .ra_data (above_data),
    .rb_data (side_data)
  );

  tlg_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .req        (req),
    .above_data (above_data),
    .side_data  (side_data),
    .out_ready  (out_tready),
    .take       (in_tready),
    .out_valid  (out_tvalid),
    .out_cell   (out_cell),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_last   (out_tlast)
  );

  assign out_tdata = {3'b000, out_col, out_row, out_cell};

`include "triangular_lattice_gas_propagation_core_defines.svh"

  // input side only stalls behind a held output beat
  `TLG_ASSERT_NOW(a_stall_cause, !in_tready, out_tvalid && !out_tready, "unexpected stall")
  // after the frame's last cell is launched the sequencer is back at row zero
  `TLG_ASSERT_NEXT(a_frame_restart, req.last && req.emit, !req.emit, "emit after frame end")

endmodule
`default_nettype wire
